@@ design/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, region codes and parameter constants for the point to
// segment squared distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int DIST_W     = 34;
    localparam int PARAM_W    = 24;
    localparam int REGION_W   = 2;
    localparam int LIMIT_W    = 21;
    localparam int FRAC_BITS  = 16;
    localparam int PINT_BITS  = 7;
    localparam int M_TDATA_W  = ((DIST_W + PARAM_W + 7) / 8) * 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    localparam logic signed [PARAM_W-1:0] PARAM_MAX  = 24'sh7FFFFF;
    localparam logic signed [PARAM_W-1:0] PARAM_MIN  = 24'sh800000;
    localparam logic signed [PARAM_W-1:0] PARAM_HALF = 24'sh008000;
    localparam logic signed [PARAM_W-1:0] PARAM_ZERO = 24'sh000000;

    typedef enum logic [REGION_W-1:0] {
        REG_A   = 2'd0,
        REG_INT = 2'd1,
        REG_B   = 2'd2,
        REG_MID = 2'd3
    } region_t;

endpackage

@@ design/psd_cell.sv @@
// ----------------------------------------------------------------------------
// psd_cell
// One step of a shift-and-reduce chain: doubles the running remainder, adds
// the operand when the leading multiplier bit is set, reduces modulo m and
// shifts the resulting quotient digit in.
// ----------------------------------------------------------------------------
module psd_cell #(
    parameter int RW = 36,
    parameter int AW = 36
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [RW-1:0] r_i,
    input  logic [RW-1:0] q_i,
    input  logic [RW-1:0] m_i,
    input  logic [RW-1:0] b_i,
    input  logic [AW-1:0] a_i,
    output logic [RW-1:0] r_o,
    output logic [RW-1:0] q_o,
    output logic [RW-1:0] m_o,
    output logic [RW-1:0] b_o,
    output logic [AW-1:0] a_o
);

    logic [RW+1:0] x0, x1, x2, m_e, add_e;
    logic          c1, c2;
    logic [RW-1:0] r_reg, q_reg, m_reg, b_reg;
    logic [AW-1:0] a_reg;

    always_comb begin
        m_e   = (RW+2)'(m_i);
        add_e = a_i[AW-1] ? (RW+2)'(b_i) : '0;
        x0    = (RW+2)'({r_i, 1'b0}) + add_e;
        c1    = (x0 >= m_e);
        x1    = c1 ? x0 - m_e : x0;
        c2    = (x1 >= m_e);
        x2    = c2 ? x1 - m_e : x1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= x2[RW-1:0];
            q_reg <= {q_i[RW-2:0], 1'b0} + RW'(c1) + RW'(c2);
            m_reg <= m_i;
            b_reg <= b_i;
            a_reg <= {a_i[AW-2:0], 1'b0};
        end
    end

    assign r_o = r_reg;
    assign q_o = q_reg;
    assign m_o = m_reg;
    assign b_o = b_reg;
    assign a_o = a_reg;

endmodule

@@ design/point_segment_distance_sq.sv @@
// ----------------------------------------------------------------------------
// point_segment_distance_sq
// Squared distance from a 3D point to a segment, projection parameter and
// region code, one item per cycle while s_tready is high.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_       | in        | tdata: px, py, pz, ax, ay, az, bx, by, bz
//  m_       | out       | tdata: dist_sq, seg_param; tuser: region
//  cfg_     | in        | data: degenerate_limit
//
//  With NC = max(2*COORD_BITS+4, 23), the path holds three arithmetic
//  stages, two rows of NC reduction cells (quotient of dot^2/l2 and of the
//  Q7.16 parameter) side by side, loaded by the classify step, one final
//  stage and the output register. One item per cycle while the output is not
//  stalled. Reset clears all valid flags and sets degenerate_limit to 1. A
//  stalled result sits in the output register while one more item drains
//  into a skid register; only then does s_tready fall.
// ----------------------------------------------------------------------------
module point_segment_distance_sq #(
    parameter int COORD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // px, py, pz, ax, ay, az, bx, by, bz from bit 0, zero padded
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // dist_sq [33:0], seg_param [57:34], zero padded
    output logic [psd_pkg::M_TDATA_W-1:0]       m_tdata,
    // region [1:0]
    output logic [psd_pkg::REGION_W-1:0]        m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psd_pkg::LIMIT_W-1:0]         cfg_data
);
    import psd_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int W2 = 2*C + 4;
    localparam int NC = (W2 > 23) ? W2 : 23;

    typedef struct packed {
        region_t         region;
        logic            neg;
        logic            ovf;
        logic            zl2;
        logic [W2-1:0]   base;
    } side_t;

    logic [LIMIT_W-1:0] limit_reg;
    logic               adv;

    logic signed [C-1:0]   crd [9];
    logic signed [C:0]     ap_reg [3], ab_reg [3], pb_reg [3];
    logic signed [C+1:0]   md_reg [3];
    logic signed [2*C+1:0] apap_reg [3], abab_reg [3], pbpb_reg [3], apab_reg [3];
    logic signed [W2-1:0]  mdmd_reg [3];
    logic [W2-1:0]         ap2_reg, l2_reg, pb2_reg, m2_reg;
    logic signed [W2-1:0]  dot_reg;
    logic [2:0]            v_reg;

    logic [W2-1:0] mag;
    logic          neg, deg, le0, ge;
    side_t         side_next;

    logic [NC-1:0] mr [NC+1], mq [NC+1], mm [NC+1], mb [NC+1];
    logic [NC-1:0] dr [NC+1], dq [NC+1], dm [NC+1], db [NC+1];
    logic [NC-1:0] ma [NC+1], da [NC+1];
    side_t         sd_reg [NC];
    logic [NC-1:0] cv_reg;

    logic [W2-1:0]              dist_full;
    logic signed [PARAM_W-1:0]  param_next;
    logic [PARAM_W-1:0]         qd24;
    side_t                      sf;

    logic [DIST_W-1:0]          fin_dist_reg, out_dist_reg, sk_dist_reg;
    logic signed [PARAM_W-1:0]  fin_par_reg, out_par_reg, sk_par_reg;
    region_t                    fin_reg_reg, out_reg_reg, sk_reg_reg;
    logic                       fin_v_reg, out_v_reg, sk_v_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    assign adv      = !sk_v_reg;
    assign s_tready = adv;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            crd[k] = s_tdata[k*C +: C];
        end
    end

    // stage 1: differences
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                ap_reg[i] <= (C+1)'(crd[i]) - (C+1)'(crd[3+i]);
                ab_reg[i] <= (C+1)'(crd[6+i]) - (C+1)'(crd[3+i]);
                pb_reg[i] <= (C+1)'(crd[i]) - (C+1)'(crd[6+i]);
                md_reg[i] <= ((C+2)'(crd[i]) <<< 1) - (C+2)'(crd[3+i]) - (C+2)'(crd[6+i]);
            end
        end
    end

    // stage 2: products
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                apap_reg[i] <= ap_reg[i] * ap_reg[i];
                abab_reg[i] <= ab_reg[i] * ab_reg[i];
                pbpb_reg[i] <= pb_reg[i] * pb_reg[i];
                apab_reg[i] <= ap_reg[i] * ab_reg[i];
                mdmd_reg[i] <= md_reg[i] * md_reg[i];
            end
        end
    end

    // stage 3: sums
    always_ff @(posedge aclk) begin
        if (adv) begin
            ap2_reg <= W2'($unsigned(apap_reg[0])) + W2'($unsigned(apap_reg[1]))
                     + W2'($unsigned(apap_reg[2]));
            l2_reg  <= W2'($unsigned(abab_reg[0])) + W2'($unsigned(abab_reg[1]))
                     + W2'($unsigned(abab_reg[2]));
            pb2_reg <= W2'($unsigned(pbpb_reg[0])) + W2'($unsigned(pbpb_reg[1]))
                     + W2'($unsigned(pbpb_reg[2]));
            dot_reg <= W2'(apab_reg[0]) + W2'(apab_reg[1]) + W2'(apab_reg[2]);
            m2_reg  <= $unsigned(mdmd_reg[0]) + $unsigned(mdmd_reg[1])
                     + $unsigned(mdmd_reg[2]);
        end
    end

    // stage 4: classify and load the cell rows
    always_comb begin
        neg = dot_reg[W2-1];
        mag = neg ? W2'(-dot_reg) : W2'(dot_reg);
        deg = ((W2+LIMIT_W)'(l2_reg) < (W2+LIMIT_W)'(limit_reg));
        le0 = neg || (dot_reg == '0);
        ge  = !neg && (mag >= l2_reg);
        side_next.neg  = neg;
        side_next.zl2  = (l2_reg == '0);
        side_next.ovf  = ((W2+PINT_BITS)'(mag) >= {l2_reg, {PINT_BITS{1'b0}}});
        priority if (deg) begin
            side_next.region = REG_MID;
            side_next.base   = m2_reg >> 2;
        end else if (le0) begin
            side_next.region = REG_A;
            side_next.base   = ap2_reg;
        end else if (ge) begin
            side_next.region = REG_B;
            side_next.base   = pb2_reg;
        end else begin
            side_next.region = REG_INT;
            side_next.base   = ap2_reg;
        end
    end

    assign mr[0] = '0;
    assign mq[0] = '0;
    assign mm[0] = NC'(l2_reg);
    assign mb[0] = NC'(mag);
    assign ma[0] = NC'(mag);
    assign dr[0] = NC'(mag >> (NC - FRAC_BITS));
    assign dq[0] = '0;
    assign dm[0] = NC'(l2_reg);
    assign db[0] = NC'(1);
    assign da[0] = NC'({mag, {FRAC_BITS{1'b0}}});

    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= side_next;
            for (int k = 1; k < NC; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < NC; g++) begin : g_row
        psd_cell #(.RW(NC), .AW(NC)) u_mul (
            .aclk(aclk), .en(adv),
            .r_i(mr[g]), .q_i(mq[g]), .m_i(mm[g]), .b_i(mb[g]), .a_i(ma[g]),
            .r_o(mr[g+1]), .q_o(mq[g+1]), .m_o(mm[g+1]), .b_o(mb[g+1]), .a_o(ma[g+1])
        );
        psd_cell #(.RW(NC), .AW(NC)) u_div (
            .aclk(aclk), .en(adv),
            .r_i(dr[g]), .q_i(dq[g]), .m_i(dm[g]), .b_i(db[g]), .a_i(da[g]),
            .r_o(dr[g+1]), .q_o(dq[g+1]), .m_o(dm[g+1]), .b_o(db[g+1]), .a_o(da[g+1])
        );
    end

    // final stage: dot^2/l2 row and the side line both have NC registers
    always_comb begin
        sf   = sd_reg[NC-1];
        qd24 = PARAM_W'(dq[NC]);
        if (sf.region == REG_INT) begin
            dist_full = sf.base - W2'(mq[NC]) - W2'(mr[NC] != '0);
        end else begin
            dist_full = sf.base;
        end
        priority if (sf.region == REG_MID) begin
            param_next = PARAM_HALF;
        end else if (sf.zl2) begin
            param_next = PARAM_ZERO;
        end else if (sf.ovf) begin
            param_next = sf.neg ? PARAM_MIN : PARAM_MAX;
        end else if (sf.neg) begin
            param_next = -$signed(qd24) - PARAM_W'(dr[NC] != '0);
        end else begin
            param_next = $signed(qd24);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            cv_reg    <= '0;
            fin_v_reg <= 1'b0;
        end else if (adv) begin
            v_reg     <= {v_reg[1:0], s_tvalid};
            cv_reg    <= {cv_reg[NC-2:0], v_reg[2]};
            fin_v_reg <= cv_reg[NC-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            fin_dist_reg <= DIST_W'(dist_full);
            fin_par_reg  <= param_next;
            fin_reg_reg  <= sf.region;
        end
    end

    // output register and skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end else begin
            if (!out_v_reg || m_tready) begin
                if (sk_v_reg) begin
                    out_v_reg <= 1'b1;
                    sk_v_reg  <= 1'b0;
                end else begin
                    out_v_reg <= fin_v_reg;
                end
            end else if (adv && fin_v_reg) begin
                sk_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_tready) begin
            if (sk_v_reg) begin
                out_dist_reg <= sk_dist_reg;
                out_par_reg  <= sk_par_reg;
                out_reg_reg  <= sk_reg_reg;
            end else begin
                out_dist_reg <= fin_dist_reg;
                out_par_reg  <= fin_par_reg;
                out_reg_reg  <= fin_reg_reg;
            end
        end else if (adv) begin
            sk_dist_reg <= fin_dist_reg;
            sk_par_reg  <= fin_par_reg;
            sk_reg_reg  <= fin_reg_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = M_TDATA_W'({out_par_reg, out_dist_reg});
    assign m_tuser  = out_reg_reg;

endmodule

@@ design/psd_checker.sv @@
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the result channel: reset, hold under stall and the
// consistency of seg_param with the region code.
// ----------------------------------------------------------------------------
module psd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [psd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [psd_pkg::REGION_W-1:0]  m_tuser
);
    import psd_pkg::*;

    logic signed [PARAM_W-1:0] par;
    assign par = m_tdata[DIST_W +: PARAM_W];

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled item changed");

    a_mid_half: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == REG_MID |-> par == PARAM_HALF)
        else $error("degenerate item without half parameter");

    a_int_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == REG_INT |-> par >= 0 && par < 65536)
        else $error("interior parameter out of range");

    a_end_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == REG_A || m_tuser == REG_B) |->
        (m_tuser == REG_A && par <= 0) || (m_tuser == REG_B && par >= 65536))
        else $error("end region parameter inconsistent");

endmodule

bind point_segment_distance_sq psd_checker u_psd_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
